// ===== design/tccw_pkg.sv =====
// Shared package of the text console character writer.
// Holds field widths, register indexes, operation codes, control characters and the result
// layout. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int MAX_COLS_DEF    = 128;
  localparam int MAX_ROWS_DEF    = 64;
  localparam int STORE_DEPTH_DEF = 8192;

  // Field widths of the stream items.
  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int ADDR_W = 13;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int LIN_W  = 13;
  localparam int CELL_W = 16;

  // Input tdata carries char_code and cell_addr, padded to whole bytes.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_ATTR = 2'd3;

  localparam int          COLS_RESET = 80;
  localparam int          ROWS_RESET = 25;
  localparam logic [7:0]  ATTR_RESET = 8'd7;

  // Operation codes carried in tuser.
  localparam logic [FUNC_W-1:0] FN_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

  // Control characters interpreted by a put, and the blank written into erased cells.
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  // Result item, cursor_col in the lowest bits.
  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [LIN_W-1:0]  cursor_linear;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } result_t;

endpackage

`default_nettype wire

// ===== design/text_console_char_writer.sv =====
// Text console character writer: cell store, cursor and the put, clear and read sequencer.
// Uses tccw_pkg for codes and widths and tccw_ram for the cell store.
//
// Usage:
//   Commands enter on the s_axis channel: tuser selects put byte, clear screen or read cell,
//   tdata carries the byte and the cell address. Every command gives exactly one result on
//   the m_axis channel: the cursor after the command, its linear index and, for a read, the
//   addressed cell (character in the low byte, attribute in the high byte).
//   Registers (columns, rows, text and clear attributes) are written through the plain
//   cfg port while no command is in flight.
// Sequencing:
//   A command is taken only while the sequencer is idle. A no-op or a put that does not
//   scroll has its result registered from the execute state unless the output register is
//   still full; no new command is taken until that result is registered. A read also passes
//   the read state, waiting for the registered RAM read port. Clear and scroll walk the area
//   in use through the single RAM read and write ports, one cell per cycle, then drain.
// Reset and stalls:
//   Reset homes the cursor and loads 80 columns, 25 rows and attribute 7; the cell store
//   is not cleared, so issue a clear before reading cells. A finished result sits in the
//   output register; if the receiver stalls while the next result is ready, the sequencer
//   waits for the output register to drain and accepts nothing meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_writer #(
  parameter int MAX_COLS    = tccw_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS    = tccw_pkg::MAX_ROWS_DEF,
  parameter int STORE_DEPTH = tccw_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration writes.
  input  wire logic                              cfg_we_i,
  input  wire logic [tccw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [tccw_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // Command stream.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: char_code [7:0], cell_addr [20:8], zero [23:21]
  input  wire logic [tccw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: func [1:0]
  input  wire logic [tccw_pkg::FUNC_W-1:0]       s_axis_tuser,
  // Result stream.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata: cursor_col [6:0], cursor_row [12:7], cursor_linear [25:13], cell_data [41:26],
  // zero [47:42]
  output logic [tccw_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int IW = $clog2(MAX_ROWS * MAX_COLS + 2 * MAX_COLS + 1);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int RES_W = $bits(tccw_pkg::result_t);

  localparam int EC_RESET = (tccw_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS : tccw_pkg::COLS_RESET;
  localparam int ER_RESET = (tccw_pkg::ROWS_RESET > MAX_ROWS) ? MAX_ROWS : tccw_pkg::ROWS_RESET;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_HOLD   = 3'd5;

  function automatic logic [CW-1:0] eff_cols(input logic [7:0] v);
    logic [CW-1:0] r;
    if (v == 8'd0) begin
      r = CW'(1);
    end else if (int'(v) > MAX_COLS) begin
      r = CW'(MAX_COLS);
    end else begin
      r = CW'(v);
    end
    return r;
  endfunction

  function automatic logic [RW-1:0] eff_rows(input logic [6:0] v);
    logic [RW-1:0] r;
    if (v == 7'd0) begin
      r = RW'(1);
    end else if (int'(v) > MAX_ROWS) begin
      r = RW'(MAX_ROWS);
    end else begin
      r = RW'(v);
    end
    return r;
  endfunction

  function automatic logic in_store(input logic [IW-1:0] idx);
    return int'(idx) < STORE_DEPTH;
  endfunction

  // Registers.
  logic [2:0]                       state_q, state_d;
  logic [tccw_pkg::FUNC_W-1:0]      fn_q;
  logic [tccw_pkg::CHAR_W-1:0]      ch_q;
  logic [tccw_pkg::ADDR_W-1:0]      addr_q;
  logic [CW-1:0]                    cur_col_q, cur_col_d;
  logic [RW-1:0]                    cur_row_q, cur_row_d;
  logic [CW-1:0]                    ec_q;
  logic [RW-1:0]                    er_q;
  logic [7:0]                       tattr_q, cattr_q;
  logic [IW-1:0]                    p_q, p_d;
  logic [IW-1:0]                    copy_end_q, copy_end_d;
  logic [IW-1:0]                    end_q, end_d;
  logic                             st_v_q, st_v_d;
  logic [IW-1:0]                    st_dst_q, st_dst_d;
  logic                             st_blank_q, st_blank_d;
  logic                             st_oob_q, st_oob_d;
  logic                             rd_oob_q, rd_oob_d;
  logic [IW-1:0]                    lin_q, lin_d;
  logic [tccw_pkg::CELL_W-1:0]      data_q, data_d;
  logic                             m_valid_q;
  tccw_pkg::result_t                m_res_q;

  // RAM ports.
  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr, ram_raddr;
  logic [tccw_pkg::CELL_W-1:0]      ram_wdata, ram_rdata;

  // Execute-stage arithmetic.
  logic [CW-1:0]                    col_c;
  logic [RW-1:0]                    row_c;
  logic [RW-1:0]                    mul_row;
  logic [RW+CW-1:0]                 prod_full;
  logic [IW-1:0]                    prod;
  logic [CW:0]                      ncol;
  logic [RW-1:0]                    nrow;
  logic                             put_wr;
  logic [CW-1:0]                    wcol;
  logic [tccw_pkg::CHAR_W-1:0]      wr_ch;
  logic                             put_scroll;
  logic [IW-1:0]                    widx;
  logic [IW-1:0]                    lin_put, lin_cur;
  logic [1:0]                       tab_step;
  logic [IW-1:0]                    src;

  // Completion.
  logic                             fin_go;
  logic [IW-1:0]                    fin_lin;
  logic [tccw_pkg::CELL_W-1:0]      fin_data;
  logic                             out_free;
  logic                             out_load;
  logic                             accept;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign out_load      = (fin_go || state_q == ST_HOLD) && out_free;

  // A put first pulls a stale cursor back into the area in use.
  assign col_c = (cur_col_q >= ec_q) ? ec_q - CW'(1) : cur_col_q;
  assign row_c = (cur_row_q >= er_q) ? er_q - RW'(1) : cur_row_q;

  always_comb begin
    case (fn_q)
      tccw_pkg::FN_PUT:   mul_row = row_c;
      tccw_pkg::FN_CLEAR: mul_row = er_q - RW'(1);
      default:            mul_row = cur_row_q;
    endcase
  end

  assign prod_full = {{CW{1'b0}}, mul_row} * {{RW{1'b0}}, ec_q};
  assign prod      = IW'(prod_full);
  assign lin_cur   = prod + IW'(cur_col_q);
  assign tab_step  = col_c[1:0] + 2'd1;

  // Byte interpretation of a put.
  always_comb begin
    ncol   = {1'b0, col_c};
    nrow   = row_c;
    put_wr = 1'b0;
    wcol   = col_c;
    wr_ch  = ch_q;
    case (ch_q)
      tccw_pkg::CH_CR: begin
        ncol = '0;
      end
      tccw_pkg::CH_LF: begin
        ncol = '0;
        nrow = row_c + RW'(1);
      end
      tccw_pkg::CH_TAB: begin
        ncol = {1'b0, col_c} + (CW + 1)'(tab_step);
      end
      tccw_pkg::CH_BS: begin
        if (col_c != '0) begin
          ncol   = {1'b0, col_c - CW'(1)};
          wcol   = col_c - CW'(1);
          wr_ch  = tccw_pkg::CH_BLANK;
          put_wr = 1'b1;
        end
      end
      default: begin
        ncol   = {1'b0, col_c} + (CW + 1)'(1);
        put_wr = 1'b1;
      end
    endcase
    if (ncol >= {1'b0, ec_q}) begin
      ncol = '0;
      nrow = nrow + RW'(1);
    end
  end

  assign put_scroll = (nrow >= er_q);
  assign widx       = prod + IW'(wcol);
  assign lin_put    = ((nrow == row_c) ? prod : prod + IW'(ec_q)) + IW'(ncol);
  assign src        = p_q + IW'(ec_q);

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    p_d        = p_q;
    copy_end_d = copy_end_q;
    end_d      = end_q;
    st_v_d     = 1'b0;
    st_dst_d   = st_dst_q;
    st_blank_d = st_blank_q;
    st_oob_d   = st_oob_q;
    rd_oob_d   = rd_oob_q;
    lin_d      = lin_q;
    data_d     = data_q;
    ram_we     = 1'b0;
    ram_waddr  = AW'(widx);
    ram_wdata  = {tattr_q, wr_ch};
    ram_raddr  = AW'(src);
    fin_go     = 1'b0;
    fin_lin    = lin_q;
    fin_data   = data_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (fn_q)
          tccw_pkg::FN_PUT: begin
            ram_we = put_wr && in_store(widx);
            if (put_scroll) begin
              // Scroll: copy every row up by one, then blank the last row.
              copy_end_d = prod;
              end_d      = prod + IW'(ec_q);
              p_d        = '0;
              cur_col_d  = '0;
              cur_row_d  = er_q - RW'(1);
              state_d    = ST_SCROLL;
            end else begin
              cur_col_d = CW'(ncol);
              cur_row_d = nrow;
              fin_go    = 1'b1;
              fin_lin   = lin_put;
              fin_data  = '0;
            end
          end
          tccw_pkg::FN_CLEAR: begin
            // A clear is a scroll with nothing to copy.
            copy_end_d = '0;
            end_d      = prod + IW'(ec_q);
            p_d        = '0;
            cur_col_d  = '0;
            cur_row_d  = '0;
            state_d    = ST_SCROLL;
          end
          tccw_pkg::FN_READ: begin
            ram_raddr = AW'(addr_q);
            rd_oob_d  = !(int'(addr_q) < STORE_DEPTH);
            lin_d     = lin_cur;
            state_d   = ST_READ;
          end
          default: begin
            fin_go   = 1'b1;
            fin_lin  = lin_cur;
            fin_data = '0;
          end
        endcase
      end
      ST_READ: begin
        fin_go   = 1'b1;
        fin_lin  = lin_q;
        fin_data = rd_oob_q ? '0 : ram_rdata;
      end
      ST_SCROLL: begin
        // The source is read one row ahead, so it is always read before it is overwritten.
        st_v_d     = 1'b1;
        st_dst_d   = p_q;
        st_blank_d = (p_q >= copy_end_q);
        st_oob_d   = !in_store(src);
        p_d        = p_q + IW'(1);
        if (p_q + IW'(1) == end_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        fin_go   = 1'b1;
        fin_lin  = copy_end_q;
        fin_data = '0;
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Write-back stage of the scroll and clear walk.
    if (st_v_q) begin
      ram_we    = in_store(st_dst_q);
      ram_waddr = AW'(st_dst_q);
      if (st_blank_q) begin
        ram_wdata = {cattr_q, tccw_pkg::CH_BLANK};
      end else if (st_oob_q) begin
        ram_wdata = '0;
      end else begin
        ram_wdata = ram_rdata;
      end
    end

    if (fin_go) begin
      lin_d   = fin_lin;
      data_d  = fin_data;
      state_d = out_free ? ST_IDLE : ST_HOLD;
    end
  end

  tccw_ram #(
    .WIDTH (tccw_pkg::CELL_W),
    .DEPTH (STORE_DEPTH)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_col_q <= '0;
      cur_row_q <= '0;
      st_v_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      st_v_q    <= st_v_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Configuration registers hold the effective sizes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_q    <= CW'(EC_RESET);
      er_q    <= RW'(ER_RESET);
      tattr_q <= tccw_pkg::ATTR_RESET;
      cattr_q <= tccw_pkg::ATTR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tccw_pkg::REG_COLUMNS:    ec_q    <= eff_cols(cfg_wdata_i);
        tccw_pkg::REG_ROWS:       er_q    <= eff_rows(cfg_wdata_i[6:0]);
        tccw_pkg::REG_TEXT_ATTR:  tattr_q <= cfg_wdata_i;
        tccw_pkg::REG_CLEAR_ATTR: cattr_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fn_q   <= s_axis_tuser;
      ch_q   <= s_axis_tdata[7:0];
      addr_q <= s_axis_tdata[20:8];
    end
    p_q        <= p_d;
    copy_end_q <= copy_end_d;
    end_q      <= end_d;
    st_dst_q   <= st_dst_d;
    st_blank_q <= st_blank_d;
    st_oob_q   <= st_oob_d;
    rd_oob_q   <= rd_oob_d;
    lin_q      <= lin_d;
    data_q     <= data_d;
    if (out_load) begin
      m_res_q.cursor_col    <= tccw_pkg::COL_W'(cur_col_d);
      m_res_q.cursor_row    <= tccw_pkg::ROW_W'(cur_row_d);
      m_res_q.cursor_linear <= tccw_pkg::LIN_W'(fin_go ? fin_lin : lin_q);
      m_res_q.cell_data     <= fin_go ? fin_data : data_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(tccw_pkg::OUT_DATA_W - RES_W){1'b0}}, m_res_q};

`ifndef SYNTHESIS
  a_no_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_HOLD) |-> !ram_we)
    else $error("cell store written while no command is in flight");

  a_put_in_area : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && fn_q == tccw_pkg::FN_PUT) |-> (cur_col_d < ec_q && cur_row_d < er_q))
    else $error("put left the cursor outside the area in use");

  a_stage_from_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_v_q |-> $past(state_q) == ST_SCROLL)
    else $error("write-back stage valid without a walk issue");

  a_hold_occupied : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOLD |-> m_valid_q)
    else $error("waiting for an output register that is already empty");

  a_sizes_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ec_q != '0 && int'(ec_q) <= MAX_COLS && er_q != '0 && int'(er_q) <= MAX_ROWS))
    else $error("effective screen size out of range");
`endif

endmodule

`default_nettype wire

// ===== design/tccw_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Width and depth are parameters. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the text console character writer, with a cursor and screen predictor.
// Drives commands and register writes, and compares every result item field by field.
// Depends on tccw_pkg and text_console_char_writer.
`timescale 1ns / 1ps

module testbench;
  import tccw_pkg::*;

  localparam int                TAB_STOP         = 4;
  localparam logic [FUNC_W-1:0] FN_NOP           = 2'd3;
  localparam int                TOTAL_CMDS       = 1150;
  localparam int                SINK_HOLD_CYCLES = 400;
  localparam int                MAX_PRINTED      = 30;

  typedef struct {
    logic [FUNC_W-1:0] op;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_addr;
  } console_cmd_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [FUNC_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Predicted console state: register copies, cursor and screen cells.
  logic [7:0]        reg_columns    = 8'(COLS_RESET);
  logic [6:0]        reg_rows       = 7'(ROWS_RESET);
  logic [7:0]        reg_text_attr  = ATTR_RESET;
  logic [7:0]        reg_clear_attr = ATTR_RESET;
  int unsigned       crsr_col       = 0;
  int unsigned       crsr_row       = 0;
  logic [CELL_W-1:0] screen [STORE_DEPTH_DEF];

  console_cmd_t cmd_queue [$];
  console_cmd_t offered;
  result_t      expected_results [$];

  int cmds_queued     = 0;
  int results_checked = 0;
  int mismatch_count  = 0;
  int src_idle_pct    = 21;
  int sink_idle_pct   = 21;
  int holds_requested = 0;
  int holds_served    = 0;
  int hold_left       = 0;

  text_console_char_writer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned eff_cols();
    if (reg_columns == 0) return 1;
    return (reg_columns > MAX_COLS_DEF) ? MAX_COLS_DEF : reg_columns;
  endfunction

  function automatic int unsigned eff_rows();
    if (reg_rows == 0) return 1;
    return (reg_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : reg_rows;
  endfunction

  function automatic void scroll_screen(int unsigned ec, int unsigned er);
    int unsigned y, x;
    for (y = 0; y + 1 < er; y++)
      for (x = 0; x < ec; x++)
        screen[y * ec + x] = screen[(y + 1) * ec + x];
    for (x = 0; x < ec; x++)
      screen[(er - 1) * ec + x] = {reg_clear_attr, CH_BLANK};
    crsr_row = er - 1;
    crsr_col = 0;
  endfunction

  function automatic void put_char(logic [CHAR_W-1:0] ch, int unsigned ec, int unsigned er);
    // A register change may have left the cursor outside the area in use.
    if (crsr_col >= ec) crsr_col = ec - 1;
    if (crsr_row >= er) crsr_row = er - 1;
    if (ch == CH_BS && crsr_col == 0) return;
    case (ch)
      CH_CR: crsr_col = 0;
      CH_LF: begin
        crsr_col = 0;
        crsr_row++;
      end
      CH_TAB: crsr_col += (crsr_col + 1) % TAB_STOP;
      CH_BS: begin
        crsr_col--;
        screen[crsr_row * ec + crsr_col] = {reg_text_attr, CH_BLANK};
      end
      default: begin
        screen[crsr_row * ec + crsr_col] = {reg_text_attr, ch};
        crsr_col++;
      end
    endcase
    if (crsr_col >= ec) begin
      crsr_col = 0;
      crsr_row++;
    end
    if (crsr_row >= er) scroll_screen(ec, er);
  endfunction

  function automatic result_t console_step(console_cmd_t cmd);
    int unsigned ec, er, i;
    result_t     res;
    ec  = eff_cols();
    er  = eff_rows();
    res = '0;
    case (cmd.op)
      FN_PUT: put_char(cmd.char_code, ec, er);
      FN_CLEAR: begin
        for (i = 0; i < ec * er; i++) screen[i] = {reg_clear_attr, CH_BLANK};
        crsr_col = 0;
        crsr_row = 0;
      end
      FN_READ: res.cell_data = screen[cmd.cell_addr];
      default: ;
    endcase
    res.cursor_col    = COL_W'(crsr_col);
    res.cursor_row    = ROW_W'(crsr_row);
    res.cursor_linear = LIN_W'(crsr_row * ec + crsr_col);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_PRINTED) $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_result(logic [OUT_DATA_W-1:0] data);
    result_t got, want;
    got = data[$bits(result_t)-1:0];
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with no command outstanding: %h", data));
      return;
    end
    want = expected_results.pop_front();
    results_checked++;
    if (got.cursor_col != want.cursor_col)
      report_mismatch($sformatf("cursor_col %0d, expected %0d", got.cursor_col,
                                want.cursor_col));
    if (got.cursor_row != want.cursor_row)
      report_mismatch($sformatf("cursor_row %0d, expected %0d", got.cursor_row,
                                want.cursor_row));
    if (got.cursor_linear != want.cursor_linear)
      report_mismatch($sformatf("cursor_linear %0d, expected %0d", got.cursor_linear,
                                want.cursor_linear));
    if (got.cell_data != want.cell_data)
      report_mismatch($sformatf("cell_data %h, expected %h", got.cell_data, want.cell_data));
  endtask

  // Command driver: the expected result is worked out when the transaction is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_results.push_back(console_step(offered));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          offered = cmd_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(IN_DATA_W - ADDR_W - CHAR_W){1'b0}}, offered.cell_addr,
                            offered.char_code};
          s_axis_tuser  <= offered.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor, which also owns the long receiver hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = SINK_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic queue_cmd(logic [FUNC_W-1:0] op, logic [CHAR_W-1:0] ch,
                           logic [ADDR_W-1:0] addr);
    console_cmd_t cmd;
    cmd.op        = op;
    cmd.char_code = ch;
    cmd.cell_addr = addr;
    cmd_queue.push_back(cmd);
    cmds_queued++;
  endtask

  task automatic queue_random_cmd();
    int unsigned       roll, area;
    logic [FUNC_W-1:0] op;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] addr;
    area = eff_cols() * eff_rows();
    op   = FN_PUT;
    ch   = CHAR_W'($urandom);
    addr = ADDR_W'($urandom);
    roll = $urandom_range(99);
    if (roll < 4) begin
      op = FN_CLEAR;
    end else if (roll < 7) begin
      op = FN_NOP;
    end else if (roll < 25) begin
      op = FN_READ;
      if ($urandom_range(3) != 0) addr = ADDR_W'($urandom_range(0, area - 1));
    end else if (roll < 50) begin
      case ($urandom_range(3))
        0:       ch = CH_CR;
        1:       ch = CH_LF;
        2:       ch = CH_TAB;
        default: ch = CH_BS;
      endcase
    end
    queue_cmd(op, ch, addr);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_COLUMNS:    reg_columns    = val;
      REG_ROWS:       reg_rows       = val[6:0];
      REG_TEXT_ATTR:  reg_text_attr  = val;
      REG_CLEAR_ATTR: reg_clear_attr = val;
      default: ;
    endcase
  endtask

  // Only called with nothing in flight. Bit i of sel picks register i.
  task automatic set_registers(logic [3:0] sel, logic [7:0] cols, logic [7:0] rws,
                               logic [7:0] t_attr, logic [7:0] c_attr);
    if (sel[0]) write_reg(REG_COLUMNS, cols);
    if (sel[1]) write_reg(REG_ROWS, rws);
    if (sel[2]) write_reg(REG_TEXT_ATTR, t_attr);
    if (sel[3]) write_reg(REG_CLEAR_ATTR, c_attr);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // The short settle is extra margin; a store walk has already finished when its result is loaded.
  task automatic wait_idle();
    while (results_checked != cmds_queued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int         i, n, p;
    logic [7:0] cols, rws;
    logic [3:0] sel;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out-of-range sizes act as the full store, so this first clear writes every cell.
    set_registers(4'b1111, 8'd255, 8'd127, 8'hFF, 8'h00);
    queue_cmd(FN_CLEAR, '0, '0);
    queue_cmd(FN_PUT, 8'h00, '0);
    queue_cmd(FN_PUT, 8'hFF, '0);
    queue_cmd(FN_PUT, "A", '0);
    repeat (3) queue_cmd(FN_PUT, CH_TAB, '0);
    queue_cmd(FN_PUT, CH_BS, '0);
    queue_cmd(FN_PUT, CH_CR, '0);
    queue_cmd(FN_PUT, CH_BS, '0);
    repeat (2) queue_cmd(FN_PUT, CH_LF, '0);
    queue_cmd(FN_READ, '0, 13'd0);
    queue_cmd(FN_READ, '0, 13'd1);
    queue_cmd(FN_READ, 8'hFF, 13'h1FFF);
    queue_cmd(FN_NOP, 8'hFF, 13'h1FFF);
    for (i = 0; i < 5; i++) queue_cmd(FN_PUT, 8'("B" + i), '0);
    queue_cmd(FN_PUT, CH_TAB, '0);
    wait_idle();

    // Zero sizes act as a single cell, and the cursor left behind is stale.
    set_registers(4'b1111, 8'd0, 8'd0, 8'h00, 8'hFF);
    queue_cmd(FN_PUT, "x", '0);
    queue_cmd(FN_PUT, CH_BS, '0);
    queue_cmd(FN_PUT, CH_TAB, '0);
    queue_cmd(FN_READ, '0, 13'd0);
    queue_cmd(FN_PUT, CH_LF, '0);
    wait_idle();

    // Full screen: walk down to the last row, scroll, and wrap a whole line.
    set_registers(4'b1111, 8'd128, 8'd64, 8'($urandom), 8'($urandom));
    for (i = 0; i < 66; i++)
      queue_cmd(FN_PUT, (i % 9 == 8) ? 8'($urandom_range(33, 126)) : CH_LF,
                ADDR_W'($urandom));
    for (i = 0; i < 150; i++)
      if (i % 25 == 24) queue_cmd(FN_READ, 8'($urandom), ADDR_W'($urandom));
      else queue_cmd(FN_PUT, 8'($urandom_range(32, 126)), ADDR_W'($urandom));
    queue_cmd(FN_CLEAR, '0, '0);
    wait_idle();

    p = 0;
    while (cmds_queued < TOTAL_CMDS) begin
      // Mostly tiny screens keep scrolls and clears short.
      if ($urandom_range(99) < 80) begin
        cols = 8'($urandom_range(0, 12));
        rws  = 8'($urandom_range(0, 6));
      end else begin
        cols = 8'($urandom_range(0, 255));
        rws  = 8'($urandom_range(0, 8));
      end
      sel = (p == 0) ? 4'b1111 : 4'($urandom_range(1, 15));
      set_registers(sel, cols, rws, 8'($urandom), 8'($urandom));
      src_idle_pct  = (p == 1 || p == 2) ? 0 : 21;
      sink_idle_pct = src_idle_pct;
      if (p == 3) holds_requested++;
      n = $urandom_range(30, 70);
      for (i = 0; i < n; i++) begin
        if (p == 5 && i == n / 2) wait_idle();
        queue_random_cmd();
      end
      wait_idle();
      p++;
    end

    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("** text_console_char_writer: PASSED **");
    end else begin
      $display("** text_console_char_writer: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(25_000_000);
    $display("** text_console_char_writer: FAILED **");
    $finish;
  end

endmodule
